>>> hdl/pei_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pei_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int TIME_BITS_DEF = 24;
  localparam int DATA_W        = 32;
  localparam int DUR_W         = 24;
  localparam int EXP_W         = 12;
  localparam int DT_W          = 16;
  localparam int CFG_IDX_W     = 3;

  localparam logic [FRAC_BITS:0] ONE_FX  = (FRAC_BITS+1)'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS:0] HALF_FX = (FRAC_BITS+1)'(1) << (FRAC_BITS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START    = 3'd0,
    CFG_TARGET   = 3'd1,
    CFG_MODE     = 3'd2,
    CFG_EXPONENT = 3'd3,
    CFG_DURATION = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_BEGIN = 2'd1,
    OP_PAUSE = 2'd2,
    OP_STOP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_IN    = 2'd0,
    MODE_OUT   = 2'd1,
    MODE_INOUT = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_POW_INT,
    ST_INT_WAIT,
    ST_FRAC,
    ST_SQRT,
    ST_FRAC_WAIT,
    ST_CURVE,
    ST_OUT_MUL,
    ST_OUT
  } state_e;

  typedef struct packed {
    op_e              operation;
    logic [DT_W-1:0]  delta_time;
  } in_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] eased_value;
    logic [FRAC_BITS:0]       eased_fraction;
    logic                     running;
  } out_rsp_t;

  typedef struct packed {
    logic start;
    logic is_sqrt;
  } ds_ctrl_t;

  typedef struct packed {
    logic done;
  } ds_stat_t;

endpackage
`default_nettype wire

>>> hdl/pei_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module pei_mul (
  input  wire logic                                   clk_i,
  input  wire logic                                   go_i,
  input  wire logic signed [pei_pkg::DATA_W:0]        a_i,
  input  wire logic signed [pei_pkg::FRAC_BITS+1:0]   b_i,
  output logic signed [pei_pkg::DATA_W+pei_pkg::FRAC_BITS+2:0] p_o
);
  import pei_pkg::*;

  logic signed [DATA_W+FRAC_BITS+2:0] p_q;

  // hold the product until the next issue
  always_ff @(posedge clk_i) begin
    if (go_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;
endmodule
`default_nettype wire

>>> hdl/pei_divsqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module pei_divsqrt #(
  parameter int TIME_BITS = pei_pkg::TIME_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire pei_pkg::ds_ctrl_t           ctrl_i,
  input  wire logic [TIME_BITS-1:0]        dividend_i,
  input  wire logic [TIME_BITS-1:0]        divisor_i,
  input  wire logic [pei_pkg::FRAC_BITS:0] radicand_i,
  output pei_pkg::ds_stat_t                stat_o,
  output logic [pei_pkg::FRAC_BITS:0]      result_o
);
  import pei_pkg::*;

  localparam int RW   = (TIME_BITS + 2 > FRAC_BITS + 5) ? TIME_BITS + 2 : FRAC_BITS + 5;
  localparam int SW   = 2 * FRAC_BITS + 2;
  localparam int CW   = $clog2(FRAC_BITS + 2);
  localparam logic [CW-1:0] LAST = CW'(FRAC_BITS);

  logic                 busy_q, busy_d, done_q, done_d, sqrt_q, sqrt_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [RW-1:0]        rem_q, rem_d;
  logic [SW-1:0]        src_q, src_d;
  logic [TIME_BITS-1:0] den_q, den_d;
  logic [FRAC_BITS:0]   res_q, res_d;

  logic [RW-1:0] opa, opb, dif, kept;
  logic          ge;

  // one shared compare and subtract: divisor for division, trial root for sqrt
  always_comb begin
    if (sqrt_q) begin
      opa = {rem_q[RW-3:0], src_q[SW-1:SW-2]};
      opb = RW'({res_q, 2'b01});
    end else begin
      opa = rem_q;
      opb = RW'(den_q);
    end
    ge   = (opa >= opb);
    dif  = opa - opb;
    kept = ge ? dif : opa;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    sqrt_d = sqrt_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    src_d  = src_q;
    den_d  = den_q;
    res_d  = res_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      sqrt_d = ctrl_i.is_sqrt;
      cnt_d  = '0;
      res_d  = '0;
      den_d  = divisor_i;
      src_d  = {1'b0, radicand_i, {FRAC_BITS{1'b0}}};
      rem_d  = ctrl_i.is_sqrt ? '0 : RW'(dividend_i);
    end else if (busy_q) begin
      res_d = {res_q[FRAC_BITS-1:0], ge};
      if (sqrt_q) begin
        rem_d = kept;
        src_d = {src_q[SW-3:0], 2'b00};
      end else begin
        rem_d = {kept[RW-2:0], 1'b0};
      end
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sqrt_q <= sqrt_d;
    cnt_q  <= cnt_d;
    rem_q  <= rem_d;
    src_q  <= src_d;
    den_q  <= den_d;
    res_q  <= res_d;
  end

  assign stat_o.done = done_q;
  assign result_o    = res_q;
endmodule
`default_nettype wire

>>> hdl/power_ease_interpolator.sv
// Begin, pause, stop, an idle tick or an undefined curve mode go straight to the output multiply; a
// running tick first runs the divide and curve setup, one multiply per integer exponent unit and a
// square root per fraction bit down to the last set one, plus a multiply when that bit is set.
// Throughput: one request at a time; the next is taken once the result is loaded into the result register.
// Reset: asynchronous, active low; run idle, configuration registers at their defaults, datapath and result not reset.
`timescale 1ns / 1ps
`default_nettype none
module power_ease_interpolator #(
  parameter int TIME_BITS = pei_pkg::TIME_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [pei_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [pei_pkg::DATA_W-1:0]      cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire pei_pkg::in_req_t                in_req_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output pei_pkg::out_rsp_t                    out_rsp_o
);
  import pei_pkg::*;

  localparam int SUMW = ((TIME_BITS > DT_W) ? TIME_BITS : DT_W) + 1;
  localparam logic [32:0] TMAX = (33'(1) << TIME_BITS) - 33'(1);
  localparam int PW = DATA_W + FRAC_BITS + 3;

  // configuration
  logic signed [DATA_W-1:0] start_q, target_q;
  logic [1:0]               mode_q;
  logic [EXP_W-1:0]         exp_q;
  logic [DUR_W-1:0]         dur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= '0;
      target_q <= '0;
      mode_q   <= MODE_OUT;
      exp_q    <= EXP_W'(512);
      dur_q    <= DUR_W'(65536);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START:    start_q  <= cfg_wdata_i;
        CFG_TARGET:   target_q <= cfg_wdata_i;
        CFG_MODE:     mode_q   <= cfg_wdata_i[1:0];
        CFG_EXPONENT: exp_q    <= cfg_wdata_i[EXP_W-1:0];
        CFG_DURATION: dur_q    <= cfg_wdata_i[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  // run state and sequencer registers
  state_e               state_q, state_d;
  logic [TIME_BITS-1:0] elapsed_q;
  logic                 active_q;
  logic [FRAC_BITS:0]   frac_q, x_q, r_q, s_q;
  logic [3:0]           cnt_q;
  logic [2:0]           k_q;
  logic                 upper_q, out_valid_q, out_valid_d;
  out_rsp_t             out_q;

  // effective duration and elapsed update
  logic [TIME_BITS-1:0] deff, el_new;
  logic [SUMW-1:0]      sum;
  logic                 act_new;
  always_comb begin
    if (dur_q == '0) begin
      deff = TIME_BITS'(1);
    end else if ({9'b0, dur_q} > TMAX) begin
      deff = TMAX[TIME_BITS-1:0];
    end else begin
      deff = TIME_BITS'({9'b0, dur_q});
    end
    sum     = SUMW'(elapsed_q) + SUMW'(in_req_i.delta_time);
    act_new = active_q;
    if (elapsed_q < deff) begin
      el_new = (sum > SUMW'(deff)) ? deff : TIME_BITS'(sum);
    end else begin
      el_new  = deff;
      act_new = 1'b0;
    end
  end

  // shared units
  ds_ctrl_t             ds_ctrl;
  ds_stat_t             ds_stat;
  logic [FRAC_BITS:0]   ds_res;
  logic                 mul_go;
  logic signed [DATA_W:0]      mul_a;
  logic signed [FRAC_BITS+1:0] mul_b;
  logic signed [PW-1:0]        mul_p;

  pei_divsqrt #(.TIME_BITS(TIME_BITS)) u_divsqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ds_ctrl),
    .dividend_i (el_new),
    .divisor_i  (deff),
    .radicand_i (s_q),
    .stat_o     (ds_stat),
    .result_o   (ds_res)
  );

  pei_mul u_mul (
    .clk_i (clk_i),
    .go_i  (mul_go),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  logic [FRAC_BITS:0] curve_prod;
  assign curve_prod = mul_p[2*FRAC_BITS:FRAC_BITS];

  logic [8:0] kmask;
  logic [7:0] frac_left;
  assign kmask     = (9'd1 << (4'(k_q) + 4'd1)) - 9'd1;
  assign frac_left = exp_q[7:0] & kmask[7:0];

  logic running_tick;
  assign running_tick = (in_req_i.operation == OP_TICK) && active_q;

  // sequencer
  always_comb begin
    state_d         = state_q;
    ds_ctrl.start   = 1'b0;
    ds_ctrl.is_sqrt = 1'b0;
    mul_go          = 1'b0;
    mul_a           = (DATA_W+1)'(r_q);
    mul_b           = {1'b0, x_q};
    // the result register stays full until taken, and loads in ST_OUT
    out_valid_d     = (state_q == ST_OUT) || (out_valid_q && !out_ready_i);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (running_tick && (mode_q <= MODE_INOUT)) begin
            ds_ctrl.start = 1'b1;
            state_d       = ST_DIV;
          end else begin
            state_d = ST_OUT_MUL;
          end
        end
      end
      ST_DIV: begin
        if (ds_stat.done) state_d = ST_POW_INT;
      end
      ST_POW_INT: begin
        if (cnt_q != '0) begin
          mul_go  = 1'b1;
          state_d = ST_INT_WAIT;
        end else begin
          state_d = ST_FRAC;
        end
      end
      ST_INT_WAIT: state_d = ST_POW_INT;
      ST_FRAC: begin
        if (frac_left == '0) begin
          state_d = ST_CURVE;
        end else begin
          ds_ctrl.start   = 1'b1;
          ds_ctrl.is_sqrt = 1'b1;
          state_d         = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (ds_stat.done) begin
          if (exp_q[k_q]) begin
            mul_go  = 1'b1;
            mul_b   = {1'b0, ds_res};
            state_d = ST_FRAC_WAIT;
          end else begin
            state_d = (k_q == '0) ? ST_CURVE : ST_FRAC;
          end
        end
      end
      ST_FRAC_WAIT: state_d = (k_q == '0) ? ST_CURVE : ST_FRAC;
      ST_CURVE:     state_d = ST_OUT_MUL;
      ST_OUT_MUL: begin
        mul_go  = 1'b1;
        mul_a   = (DATA_W+1)'(target_q) - (DATA_W+1)'(start_q);
        mul_b   = {1'b0, frac_q};
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result value: start + floor(diff * p / ONE), saturated
  logic signed [PW-FRAC_BITS-1:0] q_sh;
  logic signed [DATA_W+3:0]       v_sum;
  logic signed [DATA_W-1:0]       v_sat;
  always_comb begin
    q_sh  = mul_p[PW-1:FRAC_BITS];
    v_sum = (DATA_W+4)'(start_q) + (DATA_W+4)'(q_sh);
    if (v_sum[DATA_W+3:DATA_W-1] != '0 && v_sum[DATA_W+3:DATA_W-1] != '1) begin
      v_sat = v_sum[DATA_W+3] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      v_sat = v_sum[DATA_W-1:0];
    end
  end

  // curve fixup
  logic [FRAC_BITS:0] p_curve, x_new;
  always_comb begin
    case (mode_q)
      MODE_IN:  p_curve = r_q;
      MODE_OUT: p_curve = ONE_FX - r_q;
      default:  p_curve = upper_q ? ONE_FX - (r_q >> 1) : (r_q >> 1);
    endcase
    case (mode_q)
      MODE_IN:  x_new = ds_res;
      MODE_OUT: x_new = ONE_FX - ds_res;
      default:  x_new = (ds_res > HALF_FX) ? ((ONE_FX - ds_res) << 1) : (ds_res << 1);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      elapsed_q   <= '0;
      active_q    <= 1'b0;
      frac_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            unique case (in_req_i.operation)
              OP_TICK: begin
                if (active_q) begin
                  elapsed_q <= el_new;
                  active_q  <= act_new;
                end
              end
              OP_BEGIN: begin
                elapsed_q <= '0;
                frac_q    <= '0;
                active_q  <= 1'b1;
              end
              OP_PAUSE: active_q <= 1'b0;
              OP_STOP: begin
                active_q  <= 1'b0;
                elapsed_q <= '0;
                frac_q    <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_CURVE: frac_q <= (p_curve > ONE_FX) ? ONE_FX : p_curve;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_DIV: begin
        if (ds_stat.done) begin
          x_q     <= x_new;
          upper_q <= ds_res > HALF_FX;
          r_q     <= ONE_FX;
          cnt_q   <= exp_q[11:8];
        end
      end
      ST_POW_INT: begin
        if (cnt_q == '0) begin
          s_q <= x_q;
          k_q <= 3'd7;
        end
      end
      ST_INT_WAIT: begin
        r_q   <= curve_prod;
        cnt_q <= cnt_q - 4'd1;
      end
      ST_SQRT: begin
        if (ds_stat.done) begin
          s_q <= ds_res;
          if (!exp_q[k_q] && k_q != '0) k_q <= k_q - 3'd1;
        end
      end
      ST_FRAC_WAIT: begin
        r_q <= curve_prod;
        if (k_q != '0) k_q <= k_q - 3'd1;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_q.eased_value    <= v_sat;
          out_q.eased_fraction <= frac_q;
          out_q.running        <= active_q;
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;
endmodule
`default_nettype wire

>>> hdl/pei_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module pei_assert (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire pei_pkg::out_rsp_t out_rsp_o
);
  import pei_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while a request is in work");

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.eased_fraction <= ONE_FX)
    else $error("eased fraction above one");

  a_no_result_on_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared right after request");

endmodule

bind power_ease_interpolator pei_assert u_pei_assert (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);
`default_nettype wire
